@@ rtl/vector_terminal_coordinate_encoder_defines.svh @@
// ----------------------------------------------------------------------------
// Vector terminal coordinate encoder - assertion macros
// Shared property wrappers for the encoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef VECTOR_TERMINAL_COORDINATE_ENCODER_DEFINES_SVH
`define VECTOR_TERMINAL_COORDINATE_ENCODER_DEFINES_SVH

// Check on the rising edge of clk, suspended while rst is high.
`define VTCE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on the rising edge of clk, including reset cycles.
`define VTCE_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/vtce_pkg.sv @@
// ----------------------------------------------------------------------------
// vtce_pkg
// Widths, tags, register indexes and channel payload types of the encoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package vtce_pkg;

  localparam int COORD_W     = 10;
  localparam int CHAR_W      = 7;
  localparam int XOFF_W      = 4;
  localparam int YOFF_W      = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int NUM_CHARS   = 4;

  typedef logic [COORD_W-1:0]     coord_t;
  typedef logic [CHAR_W-1:0]      char_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;
  typedef logic [NUM_CHARS-1:0]   char_mask_t;

  localparam coord_t COORD_MAX = coord_t'(1023);
  localparam char_t  TAG_HIGH  = char_t'(7'h20);
  localparam char_t  TAG_LOW_Y = char_t'(7'h60);
  localparam char_t  TAG_LOW_X = char_t'(7'h40);

  // Character slots, in send order.
  localparam int SLOT_HIGH_Y = 0;
  localparam int SLOT_LOW_Y  = 1;
  localparam int SLOT_HIGH_X = 2;
  localparam int SLOT_LOW_X  = 3;

  // Only low X left: the final character of a point.
  localparam char_mask_t LAST_MASK = char_mask_t'(1) << SLOT_LOW_X;

  // Configuration register indexes.
  localparam cfg_index_t REG_X_OFFSET = cfg_index_t'(0);
  localparam cfg_index_t REG_Y_OFFSET = cfg_index_t'(1);

endpackage

@@ rtl/vtce_if.sv @@
// ----------------------------------------------------------------------------
// vtce_if
// Valid/ready channels of the encoder: points in, characters out, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface vtce_point_if;
  logic            valid;
  logic            ready;
  vtce_pkg::coord_t point_x;
  vtce_pkg::coord_t point_y;
  logic            send_all;

  modport source (output valid, output point_x, output point_y, output send_all,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input send_all,
                  output ready);
endinterface

interface vtce_char_if;
  logic           valid;
  logic           ready;
  vtce_pkg::char_t out_char;
  logic           last_char;

  modport source (output valid, output out_char, output last_char, input ready);
  modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

interface vtce_cfg_if;
  logic                valid;
  logic                ready;
  vtce_pkg::cfg_index_t index;
  vtce_pkg::cfg_data_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/vector_terminal_coordinate_encoder.sv @@
// ----------------------------------------------------------------------------
// vector_terminal_coordinate_encoder
// Offsets and clamps a point, packs it into four tagged 7-bit characters and
// sends the changed characters (low X always, all four on send_all).
// ----------------------------------------------------------------------------
//
//   channel | dir | payload                         | transfer when
//   --------+-----+---------------------------------+-----------------------
//   point   | in  | point_x[9:0] point_y[9:0] send_all | valid & ready
//   code    | out | out_char[6:0] last_char         | valid & ready
//   cfg     | in  | index[1:0] data[3:0]            | valid & ready (ready=1)
//
// Each point yields 1 to 4 characters, one per cycle while code is ready.
// Path: input register, then encode into the result buffer. A new point
// is taken while the previous one is still being sent; the result buffer
// loads from the input register on the cycle it empties.
// Reset (rst, synchronous) clears the offsets, the held characters and all
// valid flags. A stall on code holds the current character.
//
`timescale 1ns / 1ps
`include "vector_terminal_coordinate_encoder_defines.svh"

module vector_terminal_coordinate_encoder (
  input  logic        clk,
  input  logic        rst,
  vtce_point_if.sink  point,
  vtce_char_if.source code,
  vtce_cfg_if.sink    cfg
);

  localparam int CW = vtce_pkg::COORD_W;

  // Configuration registers.
  logic [vtce_pkg::XOFF_W-1:0] x_offset;
  logic [vtce_pkg::YOFF_W-1:0] y_offset;

  // Input register.
  logic             stage_valid;
  vtce_pkg::coord_t stage_x;
  vtce_pkg::coord_t stage_y;
  logic             stage_all;

  // Characters of the previous point, used for change detection.
  vtce_pkg::char_t held_chars [vtce_pkg::NUM_CHARS];

  // Result buffer: the four characters and a mask of those still to send.
  logic                 buf_valid;
  vtce_pkg::char_t      buf_chars [vtce_pkg::NUM_CHARS];
  vtce_pkg::char_mask_t buf_mask;

  // Encode path.
  logic [CW:0]          sum_x;
  logic [CW:0]          sum_y;
  vtce_pkg::coord_t     px;
  vtce_pkg::coord_t     py;
  vtce_pkg::char_t      enc [vtce_pkg::NUM_CHARS];
  vtce_pkg::char_mask_t mask_next;
  logic                 high_x_changed;

  // Handshake.
  logic            point_take;
  logic            out_take;
  logic            buf_last;
  logic            buf_free;
  logic            load;
  vtce_pkg::char_t sel_char;

  // Offset and clamp: the sum carries into bit CW only on overflow.
  assign sum_x = {1'b0, stage_x} + (CW+1)'(x_offset);
  assign sum_y = {1'b0, stage_y} + (CW+1)'(y_offset);
  assign px    = sum_x[CW] ? vtce_pkg::COORD_MAX : sum_x[CW-1:0];
  assign py    = sum_y[CW] ? vtce_pkg::COORD_MAX : sum_y[CW-1:0];

  // Five coordinate bits per character under its tag.
  assign enc[vtce_pkg::SLOT_HIGH_Y] = vtce_pkg::TAG_HIGH  | vtce_pkg::CHAR_W'(py[CW-1:5]);
  assign enc[vtce_pkg::SLOT_LOW_Y]  = vtce_pkg::TAG_LOW_Y | vtce_pkg::CHAR_W'(py[4:0]);
  assign enc[vtce_pkg::SLOT_HIGH_X] = vtce_pkg::TAG_HIGH  | vtce_pkg::CHAR_W'(px[CW-1:5]);
  assign enc[vtce_pkg::SLOT_LOW_X]  = vtce_pkg::TAG_LOW_X | vtce_pkg::CHAR_W'(px[4:0]);

  // Send set. A high X change drags low Y along; low X always goes out.
  // Held chars reset to zero and every tag is nonzero, so the first point
  // after reset sends all four.
  assign high_x_changed = stage_all ||
                          (enc[vtce_pkg::SLOT_HIGH_X] != held_chars[vtce_pkg::SLOT_HIGH_X]);

  always_comb begin
    mask_next = '0;
    mask_next[vtce_pkg::SLOT_HIGH_Y] = stage_all ||
        (enc[vtce_pkg::SLOT_HIGH_Y] != held_chars[vtce_pkg::SLOT_HIGH_Y]);
    mask_next[vtce_pkg::SLOT_LOW_Y]  = high_x_changed ||
        (enc[vtce_pkg::SLOT_LOW_Y] != held_chars[vtce_pkg::SLOT_LOW_Y]);
    mask_next[vtce_pkg::SLOT_HIGH_X] = high_x_changed;
    mask_next[vtce_pkg::SLOT_LOW_X]  = 1'b1;
  end

  // Lowest pending slot goes out first.
  always_comb begin
    priority if (buf_mask[vtce_pkg::SLOT_HIGH_Y]) begin
      sel_char = buf_chars[vtce_pkg::SLOT_HIGH_Y];
    end else if (buf_mask[vtce_pkg::SLOT_LOW_Y]) begin
      sel_char = buf_chars[vtce_pkg::SLOT_LOW_Y];
    end else if (buf_mask[vtce_pkg::SLOT_HIGH_X]) begin
      sel_char = buf_chars[vtce_pkg::SLOT_HIGH_X];
    end else begin
      sel_char = buf_chars[vtce_pkg::SLOT_LOW_X];
    end
  end

  assign buf_last   = (buf_mask == vtce_pkg::LAST_MASK);
  assign out_take   = buf_valid && code.ready;
  assign buf_free   = !buf_valid || (out_take && buf_last);
  assign load       = stage_valid && buf_free;
  assign point_take = point.valid && point.ready;

  assign point.ready    = !stage_valid || load;
  assign code.valid     = buf_valid;
  assign code.out_char  = sel_char;
  assign code.last_char = buf_last;
  assign cfg.ready      = 1'b1;

  // Control state, offsets and held characters.
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset    <= '0;
      y_offset    <= '0;
      stage_valid <= 1'b0;
      buf_valid   <= 1'b0;
      buf_mask    <= '0;
      for (int k = 0; k < vtce_pkg::NUM_CHARS; k++) begin
        held_chars[k] <= '0;
      end
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          vtce_pkg::REG_X_OFFSET: x_offset <= cfg.data[vtce_pkg::XOFF_W-1:0];
          vtce_pkg::REG_Y_OFFSET: y_offset <= cfg.data[vtce_pkg::YOFF_W-1:0];
          default: ; // no register there
        endcase
      end

      if (point_take) begin
        stage_valid <= 1'b1;
      end else if (load) begin
        stage_valid <= 1'b0;
      end

      if (load) begin
        buf_valid <= 1'b1;
        buf_mask  <= mask_next;
        for (int k = 0; k < vtce_pkg::NUM_CHARS; k++) begin
          held_chars[k] <= enc[k];
        end
      end else if (out_take) begin
        buf_mask <= buf_mask & (buf_mask - vtce_pkg::char_mask_t'(1));
        if (buf_last) begin
          buf_valid <= 1'b0;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (point_take) begin
      stage_x   <= point.point_x;
      stage_y   <= point.point_y;
      stage_all <= point.send_all;
    end
    if (load) begin
      for (int k = 0; k < vtce_pkg::NUM_CHARS; k++) begin
        buf_chars[k] <= enc[k];
      end
    end
  end

  // Low X is pending whenever a point is in the buffer.
  `VTCE_ASSERT(a_low_x_pending, buf_valid |-> buf_mask[vtce_pkg::SLOT_LOW_X], "low X missing from pending set")
  // A point waiting in the input register is never dropped.
  `VTCE_ASSERT(a_stage_kept, (stage_valid && !load) |=> stage_valid, "input register lost a point")
  // A stalled character keeps its pending set.
  `VTCE_ASSERT(a_stall_hold, (buf_valid && !code.ready) |=> (buf_valid && $stable(buf_mask)), "pending set changed under stall")
  // Nothing is offered once reset has been applied.
  `VTCE_ASSERT_ALWAYS(a_reset_quiet, rst |=> !buf_valid, "output valid right after reset")

endmodule
